>>> hdl/assert_macros.svh
// Assertion macros used by the top RTL file of the I/O register block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, quiet while reset is asserted.
`define CIOMD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define CIOMD_NEVER(lbl, expr, msg) \
	`CIOMD_ASSERT(lbl, !(expr), msg)

`endif

>>> hdl/ciomd_pkg.sv
// Shared types, codes and constants of the CPU I/O register block.
package ciomd_pkg;

	// Default line length in master cycles
	localparam int LINE_CYCLES_DEF = 1364;
	// H position advance per status read, and start of horizontal blank
	localparam int STATUS_STEP = 64;
	localparam int HBLANK_START = 1024;
	// One quotient bit per divider step
	localparam int DIV_STEPS = 16;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Reset values of the arithmetic and timer registers
	localparam logic [8:0]  TIMER_RST   = 9'h1ff;
	localparam logic [7:0]  MCAND_RST   = 8'hff;
	localparam logic [15:0] PROD_RST    = 16'hfe01;
	localparam logic [15:0] DIVIDND_RST = 16'hffff;
	localparam logic [15:0] QUOT_RST    = 16'h0101;

	// Command codes of an item
	typedef enum logic [1:0] {
		CMD_EVENT = 2'd0,
		CMD_READ  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_code_t;

	// Register offsets from the block base
	typedef enum logic [4:0] {
		OFF_NMITIMEN = 5'h00,
		OFF_WRIO     = 5'h01,
		OFF_WRMPYA   = 5'h02,
		OFF_WRMPYB   = 5'h03,
		OFF_WRDIVL   = 5'h04,
		OFF_WRDIVH   = 5'h05,
		OFF_WRDIVB   = 5'h06,
		OFF_HTIMEL   = 5'h07,
		OFF_HTIMEH   = 5'h08,
		OFF_VTIMEL   = 5'h09,
		OFF_VTIMEH   = 5'h0a,
		OFF_MDMAEN   = 5'h0b,
		OFF_HDMAEN   = 5'h0c,
		OFF_RDNMI    = 5'h10,
		OFF_TIMEUP   = 5'h11,
		OFF_HVBJOY   = 5'h12,
		OFF_RDIO     = 5'h13,
		OFF_RDDIVL   = 5'h14,
		OFF_RDDIVH   = 5'h15,
		OFF_RDMPYL   = 5'h16,
		OFF_RDMPYH   = 5'h17,
		OFF_JOY1L    = 5'h18,
		OFF_JOY1H    = 5'h19,
		OFF_JOY2L    = 5'h1a,
		OFF_JOY2H    = 5'h1b
	} reg_off_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic div_step;
		logic div_last;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic div_req;
	} dp_status_t;

	// Full 16-bit bit reversal of a joypad word
	function automatic logic [15:0] rev16(input logic [15:0] v);
		logic [15:0] r;
		for (int i = 0; i < 16; i++) begin
			r[i] = v[15 - i];
		end
		return r;
	endfunction

endpackage

>>> hdl/ciomd_ctrl.sv
// Controller: item handshake and sequencing of the iterative divider.
module ciomd_ctrl import ciomd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DIV,
		S_OUT
	} state_t;

	state_t               state_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 req_ready_q;
	logic                 rsp_valid_q;
	logic                 accept;
	logic                 last_step;

	assign accept    = req_valid & req_ready_q;
	assign last_step = (state_q == S_DIV) && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));

	assign cmd.accept   = accept;
	assign cmd.div_step = (state_q == S_DIV);
	assign cmd.div_last = last_step;

	assign req_ready = req_ready_q;
	assign rsp_valid = rsp_valid_q;

	// State, step count and handshake flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			req_ready_q <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_ready_q <= 1'b0;
						cnt_q       <= '0;
						if (status.div_req) begin
							state_q <= S_DIV;
						end else begin
							state_q     <= S_OUT;
							rsp_valid_q <= 1'b1;
						end
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (last_step) begin
						state_q     <= S_OUT;
						rsp_valid_q <= 1'b1;
					end
				end
				S_OUT: begin
					if (rsp_ready) begin
						state_q     <= S_IDLE;
						rsp_valid_q <= 1'b0;
						req_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					req_ready_q <= 1'b1;
					rsp_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

>>> hdl/ciomd_dp.sv
// Datapath: register file, event flags, multiplier and restoring divider.
module ciomd_dp import ciomd_pkg::*; #(
	parameter int LINE_CYCLES = LINE_CYCLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	input  logic [1:0]  req_cmd,
	input  logic [4:0]  reg_offset,
	input  logic [7:0]  write_data,
	input  logic        nmi_set,
	input  logic        irq_set,
	input  logic        force_nmi,
	input  logic        in_vblank,
	input  logic        autojoy_begin,
	input  logic        autojoy_end,
	input  logic [15:0] pad1_state,
	input  logic [15:0] pad2_state,
	output logic [7:0]  read_data,
	output logic        nmi_enable,
	output logic        hirq_enable,
	output logic        virq_enable,
	output logic [8:0]  h_timer,
	output logic [8:0]  v_timer,
	output logic        counter_latch_release,
	output logic        gdma_start,
	output logic        hdma_start,
	output logic [7:0]  dma_mask,
	output logic        irq_pending
);

	localparam int HPOS_W = $clog2(LINE_CYCLES);

	// Architectural state
	logic              nmi_flag_q, irq_flag_q, aj_en_q, aj_busy_q;
	logic              hirq_en_q, virq_en_q, nmi_en_q, latch_q;
	logic [8:0]        htimer_q, vtimer_q;
	logic [7:0]        mcand_q;
	logic [15:0]       prod_q, dividend_q, quot_q;
	logic [HPOS_W-1:0] hpos_q;

	// Result item registers
	logic [7:0] rdata_q, mask_q;
	logic       release_q, gdma_q, hdma_q;

	// Divider working registers
	logic [15:0] div_rem_q, div_quo_q;
	logic [7:0]  div_dsr_q;

	// Next values for an accepted item
	logic              nmi_n, irq_n, aj_en_n, aj_busy_n;
	logic              hirq_en_n, virq_en_n, nmi_en_n, latch_n;
	logic [8:0]        htimer_n, vtimer_n;
	logic [7:0]        mcand_n;
	logic [15:0]       prod_n, dividend_n;
	logic [HPOS_W-1:0] hpos_n;
	logic [7:0]        rdata_n, mask_n;
	logic              release_n, gdma_n, hdma_n;
	logic [HPOS_W:0]   hpos_sum;
	logic [HPOS_W-1:0] hpos_adv;
	logic [15:0]       pad1_rev, pad2_rev;
	logic              is_read, is_write;

	// Divider step
	logic [16:0] div_trial;
	logic        div_ge;
	logic [16:0] div_diff;
	logic [15:0] div_rem_n, div_quo_n;

	assign is_read  = (req_cmd == CMD_READ);
	assign is_write = (req_cmd == CMD_WRITE);
	assign status.div_req = is_write && (reg_offset == OFF_WRDIVB);

	assign pad1_rev = rev16(pad1_state);
	assign pad2_rev = rev16(pad2_state);

	// Status read moves the H position on, wrapping at the line length
	assign hpos_sum = {1'b0, hpos_q} + (HPOS_W+1)'(STATUS_STEP);
	assign hpos_adv = (hpos_sum >= (HPOS_W+1)'(LINE_CYCLES))
		? HPOS_W'(hpos_sum - (HPOS_W+1)'(LINE_CYCLES)) : HPOS_W'(hpos_sum);

	// Events first, then the read or write access
	always_comb begin
		nmi_n      = nmi_flag_q | nmi_set;
		irq_n      = irq_flag_q | irq_set;
		aj_busy_n  = (aj_busy_q | (autojoy_begin & aj_en_q)) & ~autojoy_end;
		aj_en_n    = aj_en_q;
		hirq_en_n  = hirq_en_q;
		virq_en_n  = virq_en_q;
		nmi_en_n   = nmi_en_q;
		latch_n    = latch_q;
		htimer_n   = htimer_q;
		vtimer_n   = vtimer_q;
		mcand_n    = mcand_q;
		prod_n     = prod_q;
		dividend_n = dividend_q;
		hpos_n     = hpos_q;
		rdata_n    = 8'h00;
		mask_n     = 8'h00;
		release_n  = 1'b0;
		gdma_n     = 1'b0;
		hdma_n     = 1'b0;
		if (is_read) begin
			case (reg_offset)
				OFF_RDNMI: begin
					rdata_n = {(nmi_n | force_nmi), 7'h02};
					nmi_n   = 1'b0;
				end
				OFF_TIMEUP: begin
					rdata_n = {irq_n, 7'h00};
					irq_n   = 1'b0;
				end
				OFF_HVBJOY: begin
					hpos_n  = hpos_adv;
					rdata_n = {in_vblank, (hpos_adv >= HPOS_W'(HBLANK_START)), 5'h00,
						aj_busy_n};
				end
				OFF_RDIO:  rdata_n = {latch_q, 7'h00};
				OFF_RDDIVL: rdata_n = quot_q[7:0];
				OFF_RDDIVH: rdata_n = quot_q[15:8];
				OFF_RDMPYL: rdata_n = prod_q[7:0];
				OFF_RDMPYH: rdata_n = prod_q[15:8];
				OFF_JOY1L:  rdata_n = pad1_rev[7:0];
				OFF_JOY1H:  rdata_n = pad1_rev[15:8];
				OFF_JOY2L:  rdata_n = pad2_rev[7:0];
				OFF_JOY2H:  rdata_n = pad2_rev[15:8];
				default:    rdata_n = 8'h00;
			endcase
		end else if (is_write) begin
			case (reg_offset)
				OFF_NMITIMEN: begin
					aj_en_n   = write_data[0];
					if (!write_data[0]) begin
						aj_busy_n = 1'b0;
					end
					hirq_en_n = write_data[4];
					virq_en_n = write_data[5];
					nmi_en_n  = write_data[7];
					if (!write_data[4] && !write_data[5]) begin
						irq_n = 1'b0;
					end
				end
				OFF_WRIO: begin
					release_n = latch_q & ~write_data[7];
					latch_n   = write_data[7];
				end
				OFF_WRMPYA: mcand_n = write_data;
				OFF_WRMPYB: prod_n = 16'(mcand_q) * 16'(write_data);
				OFF_WRDIVL: dividend_n = {dividend_q[15:8], write_data};
				OFF_WRDIVH: dividend_n = {write_data, dividend_q[7:0]};
				OFF_HTIMEL: htimer_n = {htimer_q[8], write_data};
				OFF_HTIMEH: htimer_n = {write_data[0], htimer_q[7:0]};
				OFF_VTIMEL: vtimer_n = {vtimer_q[8], write_data};
				OFF_VTIMEH: vtimer_n = {write_data[0], vtimer_q[7:0]};
				OFF_MDMAEN: begin
					gdma_n = 1'b1;
					mask_n = write_data;
				end
				OFF_HDMAEN: begin
					hdma_n = 1'b1;
					mask_n = write_data;
				end
				default: ;
			endcase
		end
	end

	// Restoring division, one quotient bit per step; a zero divisor
	// naturally yields all-ones quotient and remainder equal to dividend
	assign div_trial = {div_rem_q, div_quo_q[15]};
	assign div_ge    = (div_trial >= {9'h000, div_dsr_q});
	assign div_diff  = div_trial - {9'h000, div_dsr_q};
	assign div_rem_n = div_ge ? div_diff[15:0] : div_trial[15:0];
	assign div_quo_n = {div_quo_q[14:0], div_ge};

	// Architectural state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nmi_flag_q <= 1'b0;
			irq_flag_q <= 1'b0;
			aj_en_q    <= 1'b0;
			aj_busy_q  <= 1'b0;
			hirq_en_q  <= 1'b0;
			virq_en_q  <= 1'b0;
			nmi_en_q   <= 1'b0;
			latch_q    <= 1'b0;
			htimer_q   <= TIMER_RST;
			vtimer_q   <= TIMER_RST;
			mcand_q    <= MCAND_RST;
			prod_q     <= PROD_RST;
			dividend_q <= DIVIDND_RST;
			quot_q     <= QUOT_RST;
			hpos_q     <= '0;
		end else if (cmd.accept) begin
			nmi_flag_q <= nmi_n;
			irq_flag_q <= irq_n;
			aj_en_q    <= aj_en_n;
			aj_busy_q  <= aj_busy_n;
			hirq_en_q  <= hirq_en_n;
			virq_en_q  <= virq_en_n;
			nmi_en_q   <= nmi_en_n;
			latch_q    <= latch_n;
			htimer_q   <= htimer_n;
			vtimer_q   <= vtimer_n;
			mcand_q    <= mcand_n;
			prod_q     <= prod_n;
			dividend_q <= dividend_n;
			hpos_q     <= hpos_n;
		end else if (cmd.div_last) begin
			quot_q <= div_quo_n;
			prod_q <= div_rem_n;
		end
	end

	// Result item and divider operands
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rdata_q   <= rdata_n;
			mask_q    <= mask_n;
			release_q <= release_n;
			gdma_q    <= gdma_n;
			hdma_q    <= hdma_n;
			div_rem_q <= '0;
			div_quo_q <= dividend_q;
			div_dsr_q <= write_data;
		end else if (cmd.div_step) begin
			div_rem_q <= div_rem_n;
			div_quo_q <= div_quo_n;
		end
	end

	assign read_data             = rdata_q;
	assign nmi_enable            = nmi_en_q;
	assign hirq_enable           = hirq_en_q;
	assign virq_enable           = virq_en_q;
	assign h_timer               = htimer_q;
	assign v_timer               = vtimer_q;
	assign counter_latch_release = release_q;
	assign gdma_start            = gdma_q;
	assign hdma_start            = hdma_q;
	assign dma_mask              = mask_q;
	assign irq_pending           = irq_flag_q;

endmodule

>>> hdl/cpu_io_registers_mul_div_irq.sv
// CPU I/O register block at offsets 0x00-0x1F: interrupts, timers, mul/div.
//
// Request channel (req_valid/req_ready) carries one bus item: its event
// pulses (NMI, IRQ, auto-joypad begin/end) are applied first, then the
// optional register read or write given by cmd and reg_offset.
// Response channel (rsp_valid/rsp_ready) returns one result item per request:
// the read byte, the enables and timers, the DMA start pulses and IRQ flag.
// The result is registered and valid in the cycle after acceptance, or, for
// a divide write (offset 0x06), once its 16 quotient bits have come from a
// restoring divider that resolves one bit per cycle.
// One item is in flight at a time: the next request is taken only after the
// receiver takes the result with rsp_ready.
// While the receiver stalls the result stays on the ports unchanged and no new
// request is taken. The 8x8 multiply completes in the accept cycle.
// Asynchronous reset (arst_n low) returns the state registers to their power-up
// values (timers 0x1FF, product 0xFE01, dividend 0xFFFF, quotient 0x0101),
// does not reset the result item registers, and leaves the block ready for a request.
module cpu_io_registers_mul_div_irq import ciomd_pkg::*; #(
	parameter int LINE_CYCLES = LINE_CYCLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  cmd,
	input  logic [4:0]  reg_offset,
	input  logic [7:0]  write_data,
	input  logic        nmi_set,
	input  logic        irq_set,
	input  logic        force_nmi,
	input  logic        in_vblank,
	input  logic        autojoy_begin,
	input  logic        autojoy_end,
	input  logic [15:0] pad1_state,
	input  logic [15:0] pad2_state,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [7:0]  read_data,
	output logic        nmi_enable,
	output logic        hirq_enable,
	output logic        virq_enable,
	output logic [8:0]  h_timer,
	output logic [8:0]  v_timer,
	output logic        counter_latch_release,
	output logic        gdma_start,
	output logic        hdma_start,
	output logic [7:0]  dma_mask,
	output logic        irq_pending
);

`include "assert_macros.svh"

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	ciomd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.status    (dp_status),
		.cmd       (dp_cmd)
	);

	ciomd_dp #(
		.LINE_CYCLES (LINE_CYCLES)
	) u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (dp_cmd),
		.status                (dp_status),
		.req_cmd               (cmd),
		.reg_offset            (reg_offset),
		.write_data            (write_data),
		.nmi_set               (nmi_set),
		.irq_set               (irq_set),
		.force_nmi             (force_nmi),
		.in_vblank             (in_vblank),
		.autojoy_begin         (autojoy_begin),
		.autojoy_end           (autojoy_end),
		.pad1_state            (pad1_state),
		.pad2_state            (pad2_state),
		.read_data             (read_data),
		.nmi_enable            (nmi_enable),
		.hirq_enable           (hirq_enable),
		.virq_enable           (virq_enable),
		.h_timer               (h_timer),
		.v_timer               (v_timer),
		.counter_latch_release (counter_latch_release),
		.gdma_start            (gdma_start),
		.hdma_start            (hdma_start),
		.dma_mask              (dma_mask),
		.irq_pending           (irq_pending)
	);

	// Checks on the controller and result fields
	`CIOMD_NEVER(a_ready_and_valid, req_ready && rsp_valid, "request taken while result pending")
	`CIOMD_ASSERT(a_one_in_flight, req_valid && req_ready |=> !req_ready, "second item taken")
	`CIOMD_NEVER(a_dma_both, rsp_valid && gdma_start && hdma_start, "both DMA starts in one item")
	`CIOMD_ASSERT(a_mask_idle, rsp_valid && !gdma_start && !hdma_start |-> dma_mask == 8'h00, "DMA mask without start")

endmodule
